### design/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg: shared constants and types for the console bus memory map
// Region codes, function codes, special addresses and the controller state.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam int VRAM_BYTES = 8192;
	localparam int WRAM_BYTES = 8192;
	localparam int OAM_BYTES  = 160;
	localparam int BOOT_BYTES = 256;
	localparam int IO_BYTES   = 128;
	localparam int HRAM_BYTES = 127;

	localparam int VRAM_AW = $clog2(VRAM_BYTES);
	localparam int WRAM_AW = $clog2(WRAM_BYTES);
	localparam int OAM_AW  = $clog2(OAM_BYTES);
	localparam int BOOT_AW = (BOOT_BYTES > 1) ? $clog2(BOOT_BYTES) : 1;
	localparam int CLR_AW  = 13;

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_BOOT  = 2'd2;

	localparam logic [15:0] ADDR_DMA    = 16'hFF46;
	localparam logic [15:0] ADDR_STAT   = 16'hFF41;
	localparam logic [15:0] ADDR_LY     = 16'hFF44;
	localparam logic [15:0] ADDR_BOOTOFF = 16'hFF50;
	localparam logic [15:0] ADDR_ECHO_LO = 16'hE000;
	localparam logic [15:0] ADDR_ECHO_HI = 16'hFDFF;
	localparam logic [15:0] ECHO_OFFSET  = 16'h2000;
	localparam logic [15:0] ADDR_OAM     = 16'hFE00;
	localparam logic [15:0] ADDR_OAM_END = 16'hFEA0;
	localparam logic [15:0] ADDR_IO      = 16'hFF00;
	localparam logic [15:0] ADDR_HRAM    = 16'hFF80;
	localparam logic [15:0] ADDR_IE      = 16'hFFFF;
	localparam logic [7:0]  STAT_KEEP    = 8'h07;
	localparam logic [7:0]  STAT_TAKE    = 8'h78;

	typedef enum logic [2:0] {
		REG_NONE, REG_VRAM, REG_WRAM, REG_OAM, REG_IO, REG_HRAM, REG_IE, REG_BOOT
	} region_t;

	typedef struct packed {
		region_t     region;
		logic [12:0] offset;
	} decode_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_DMA_RD, ST_DMA_WR
	} state_t;

	// Map a bus address to a region and an offset inside that region.
	function automatic decode_t decode(logic [15:0] a_in, logic overlay);
		decode_t     d;
		logic [15:0] a;
		logic [15:0] o;
		a = a_in;
		if (a >= ADDR_ECHO_LO && a <= ADDR_ECHO_HI)
			a = a - ECHO_OFFSET;
		d.region = REG_NONE;
		o = 16'd0;
		if (overlay && a_in < 16'(BOOT_BYTES) && a_in < 16'h0100) begin
			d.region = REG_BOOT; o = a_in;
		end else if (a >= 16'h8000 && a < 16'hA000) begin
			d.region = REG_VRAM; o = a - 16'h8000;
		end else if (a >= 16'hC000 && a < 16'hE000) begin
			d.region = REG_WRAM; o = a - 16'hC000;
		end else if (a >= ADDR_OAM && a < ADDR_OAM_END) begin
			d.region = REG_OAM; o = a - ADDR_OAM;
		end else if (a >= ADDR_IO && a < ADDR_HRAM) begin
			d.region = REG_IO; o = a - ADDR_IO;
		end else if (a >= ADDR_HRAM && a < ADDR_IE) begin
			d.region = REG_HRAM; o = a - ADDR_HRAM;
		end else if (a == ADDR_IE) begin
			d.region = REG_IE;
		end
		d.offset = o[12:0];
		return d;
	endfunction

endpackage

### design/cbm_ram.sv
// ----------------------------------------------------------------------------
// cbm_ram: generic single-port synchronous RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module cbm_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

### design/cbm_store.sv
// ----------------------------------------------------------------------------
// cbm_store: all byte stores of the map
// Routes one access per cycle to the region selected by the decode.
// ----------------------------------------------------------------------------
module cbm_store (
	input  logic                clk,
	input  logic                clr,
	input  cbm_pkg::region_t    region,
	input  logic [12:0]         offset,
	input  logic                we,
	input  logic [7:0]          wdata,
	output logic [7:0]          rdata
);
	logic [7:0] vram_rd, wram_rd, oam_rd, io_rd, hram_rd, boot_rd;
	logic [7:0] ie_q;
	cbm_pkg::region_t region_s1;
	logic       vram_we, wram_we, oam_we, io_we, hram_we, boot_we;
	logic [7:0] vram_wd, fill_wd;

	// The clearing pass writes every store but the boot image in the same cycle; OAM and HRAM only below their size.
	assign vram_we = clr || (we && region == cbm_pkg::REG_VRAM);
	assign wram_we = clr || (we && region == cbm_pkg::REG_WRAM);
	assign oam_we  = (clr && offset < 13'(cbm_pkg::OAM_BYTES)) ||
		(we && region == cbm_pkg::REG_OAM);
	assign io_we   = clr || (we && region == cbm_pkg::REG_IO);
	assign hram_we = (clr && offset < 13'(cbm_pkg::HRAM_BYTES)) ||
		(we && region == cbm_pkg::REG_HRAM);
	assign boot_we = we && region == cbm_pkg::REG_BOOT;
	assign vram_wd = clr ? 8'h00 : wdata;
	assign fill_wd = clr ? 8'hFF : wdata;

	cbm_ram #(.DEPTH(cbm_pkg::VRAM_BYTES), .AW(cbm_pkg::VRAM_AW)) u_vram (
		.clk, .we(vram_we),
		.addr(offset[cbm_pkg::VRAM_AW-1:0]), .wdata(vram_wd), .rdata(vram_rd));
	cbm_ram #(.DEPTH(cbm_pkg::WRAM_BYTES), .AW(cbm_pkg::WRAM_AW)) u_wram (
		.clk, .we(wram_we),
		.addr(offset[cbm_pkg::WRAM_AW-1:0]), .wdata(fill_wd), .rdata(wram_rd));
	cbm_ram #(.DEPTH(cbm_pkg::OAM_BYTES), .AW(cbm_pkg::OAM_AW)) u_oam (
		.clk, .we(oam_we),
		.addr(offset[cbm_pkg::OAM_AW-1:0]), .wdata(fill_wd), .rdata(oam_rd));
	cbm_ram #(.DEPTH(cbm_pkg::IO_BYTES), .AW(7)) u_io (
		.clk, .we(io_we),
		.addr(offset[6:0]), .wdata(fill_wd), .rdata(io_rd));
	cbm_ram #(.DEPTH(cbm_pkg::HRAM_BYTES), .AW(7)) u_hram (
		.clk, .we(hram_we),
		.addr(offset[6:0]), .wdata(fill_wd), .rdata(hram_rd));
	cbm_ram #(.DEPTH(cbm_pkg::BOOT_BYTES), .AW(cbm_pkg::BOOT_AW)) u_boot (
		.clk, .we(boot_we),
		.addr(offset[cbm_pkg::BOOT_AW-1:0]), .wdata, .rdata(boot_rd));

	always_ff @(posedge clk) begin
		region_s1 <= region;
		if (clr)
			ie_q <= 8'hFF;
		else if (we && region == cbm_pkg::REG_IE)
			ie_q <= wdata;
	end

	always_comb begin
		case (region_s1)
			cbm_pkg::REG_VRAM: rdata = vram_rd;
			cbm_pkg::REG_WRAM: rdata = wram_rd;
			cbm_pkg::REG_OAM:  rdata = oam_rd;
			cbm_pkg::REG_IO:   rdata = io_rd;
			cbm_pkg::REG_HRAM: rdata = hram_rd;
			cbm_pkg::REG_IE:   rdata = ie_q;
			cbm_pkg::REG_BOOT: rdata = boot_rd;
			default:           rdata = 8'hFF;
		endcase
	end
endmodule

### design/console_bus_memory_map_core.sv
// ----------------------------------------------------------------------------
// console_bus_memory_map_core: byte bus decoder with sprite RAM copy
// One CPU byte access per command; stores held in single-port RAMs.
// ----------------------------------------------------------------------------
// Usage: raise start with func, address and data while busy is low. The
// command is taken at that edge. Exactly one word comes back on read_data,
// marked by done for one cycle: the byte read for func 0, zero otherwise.
// The receiver cannot stall; done is not held.
// Timing: a write, boot load or unused func answers in the cycle after it is
// taken; a read answers once the registered RAM output is captured into
// read_data in the ST_READ state, and holds busy for one cycle.
// A write of a value other than FF to FF46 copies 160 bytes through the
// same decode, one read and one write per byte on the single RAM port:
// busy stays high while ST_DMA_RD and ST_DMA_WR alternate, and the word
// answers once the last byte is written. Throughput: one command per cycle
// for writes and boot loads that start no copy; reads are not overlapped, as busy stays high in ST_READ.
// Reset: a clearing pass writes the reset values into all stores but the
// boot image (video RAM 00, others FF) with busy high; the boot overlay is
// off.
// The FF41 and FF44 write rules and the FF50 gate are applied here.
// ----------------------------------------------------------------------------
module console_bus_memory_map_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	output logic        done,
	output logic [7:0]  read_data
);
	cbm_pkg::state_t state_q, state_d;
	logic [cbm_pkg::CLR_AW-1:0] clr_addr;
	logic        clr_last;
	logic        clr_wr;
	logic [7:0]  dma_q;
	logic [cbm_pkg::OAM_AW-1:0] idx_q;
	logic        overlay_q;
	logic [7:0]  stat_q;
	logic        done_q;
	logic [7:0]  rd_q;

	cbm_pkg::region_t mem_region;
	logic [12:0]      mem_offset;
	logic             mem_we;
	logic [7:0]       mem_wdata, mem_rdata;
	cbm_pkg::decode_t dec_in, dec_wr, dec_src;
	logic [15:0]      eff_addr, src_addr;
	logic [7:0]       wval;
	logic             accept;
	logic             dma_go;
	logic             dma_last;

	assign clr_wr = state_q == cbm_pkg::ST_CLEAR;

	cbm_store u_store (
		.clk, .clr(clr_wr), .region(mem_region), .offset(mem_offset),
		.we(mem_we), .wdata(mem_wdata), .rdata(mem_rdata));

	cbm_clear u_clear (.clk, .arst_n, .en(clr_wr), .addr(clr_addr), .last(clr_last));

	assign accept   = start && state_q == cbm_pkg::ST_IDLE;
	assign busy     = state_q != cbm_pkg::ST_IDLE;
	assign dma_go   = func == cbm_pkg::FUNC_WRITE && eff_addr == cbm_pkg::ADDR_DMA &&
		data != 8'hFF;
	assign dma_last = idx_q == cbm_pkg::OAM_AW'(cbm_pkg::OAM_BYTES - 1);

	always_comb begin
		eff_addr = address;
		if (address >= cbm_pkg::ADDR_ECHO_LO && address <= cbm_pkg::ADDR_ECHO_HI)
			eff_addr = address - cbm_pkg::ECHO_OFFSET;
		dec_in   = cbm_pkg::decode(address, overlay_q);
		dec_wr   = cbm_pkg::decode(address, 1'b0);
		src_addr = {dma_q, 8'(idx_q)};
		dec_src  = cbm_pkg::decode(src_addr, overlay_q);
		case (eff_addr)
			cbm_pkg::ADDR_STAT: wval = (stat_q & cbm_pkg::STAT_KEEP) |
				(data & cbm_pkg::STAT_TAKE);
			cbm_pkg::ADDR_LY:   wval = 8'h00;
			default:            wval = data;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		mem_region = cbm_pkg::REG_NONE;
		mem_offset = 13'd0;
		mem_we     = 1'b0;
		mem_wdata  = data;
		case (state_q)
			cbm_pkg::ST_CLEAR: begin
				mem_offset = clr_addr;
				if (clr_last)
					state_d = cbm_pkg::ST_IDLE;
			end
			cbm_pkg::ST_IDLE: begin
				if (accept) begin
					if (func == cbm_pkg::FUNC_READ) begin
						mem_region = dec_in.region;
						mem_offset = dec_in.offset;
						state_d    = cbm_pkg::ST_READ;
					end else if (func == cbm_pkg::FUNC_WRITE) begin
						mem_region = dec_wr.region;
						mem_offset = dec_wr.offset;
						mem_wdata  = wval;
						mem_we     = !(eff_addr == cbm_pkg::ADDR_BOOTOFF && data == 8'h00);
						if (dma_go)
							state_d = cbm_pkg::ST_DMA_RD;
					end else if (func == cbm_pkg::FUNC_BOOT &&
					             address < 16'(cbm_pkg::BOOT_BYTES)) begin
						mem_region = cbm_pkg::REG_BOOT;
						mem_offset = address[12:0];
						mem_we     = 1'b1;
					end
				end
			end
			cbm_pkg::ST_READ: state_d = cbm_pkg::ST_IDLE;
			cbm_pkg::ST_DMA_RD: begin
				mem_region = dec_src.region;
				mem_offset = dec_src.offset;
				state_d    = cbm_pkg::ST_DMA_WR;
			end
			cbm_pkg::ST_DMA_WR: begin
				mem_region = cbm_pkg::REG_OAM;
				mem_offset = 13'(idx_q);
				mem_we     = 1'b1;
				mem_wdata  = mem_rdata;
				state_d    = dma_last ? cbm_pkg::ST_IDLE : cbm_pkg::ST_DMA_RD;
			end
			default: state_d = cbm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cbm_pkg::ST_CLEAR;
			idx_q     <= '0;
			overlay_q <= 1'b0;
			done_q    <= 1'b0;
			stat_q    <= 8'hFF;
		end else begin
			state_q <= state_d;
			// a sprite copy answers once its last byte is written
			done_q  <= (accept && func != cbm_pkg::FUNC_READ && !dma_go) ||
				state_q == cbm_pkg::ST_READ ||
				(state_q == cbm_pkg::ST_DMA_WR && dma_last);
			if (accept) begin
				if (func == cbm_pkg::FUNC_WRITE) begin
					if (eff_addr == cbm_pkg::ADDR_BOOTOFF && data != 8'h00)
						overlay_q <= 1'b0;
					if (eff_addr == cbm_pkg::ADDR_STAT)
						stat_q <= wval;
				end
				if (func == cbm_pkg::FUNC_BOOT && address < 16'(cbm_pkg::BOOT_BYTES))
					overlay_q <= 1'b1;
				idx_q <= '0;
			end
			if (state_q == cbm_pkg::ST_DMA_WR)
				idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= 8'h00;
			if (func == cbm_pkg::FUNC_WRITE && eff_addr == cbm_pkg::ADDR_DMA)
				dma_q <= data;
		end
		if (state_q == cbm_pkg::ST_READ)
			rd_q <= mem_rdata;
	end

	assign done      = done_q;
	assign read_data = rd_q;
endmodule

### design/cbm_clear.sv
// ----------------------------------------------------------------------------
// cbm_clear: clear sequencer
// Steps the store address through every entry while the clearing pass runs.
// ----------------------------------------------------------------------------
module cbm_clear (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	output logic [cbm_pkg::CLR_AW-1:0] addr,
	output logic                       last
);
	logic [cbm_pkg::CLR_AW-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			addr_q <= '0;
		else if (en)
			addr_q <= addr_q + 1'b1;
	end

	assign addr = addr_q;
	assign last = &addr_q;
endmodule
